@@ rtl/tsv_pkg.sv @@
// ----------------------------------------------------------------------------
// tsv_pkg
// Shared constants, types and the month length table for the timestamp
// string validator.
// ----------------------------------------------------------------------------
package tsv_pkg;

    localparam int unsigned TS_LENGTH = 16;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned FIELD_W   = 7;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned DAYS_W    = 5;

    localparam logic [POS_W-1:0] POS_MAX     = 5'd31;
    localparam logic [POS_W-1:0] POS_LAST    = 5'd15;
    localparam logic [POS_W-1:0] POS_DASH_Y  = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH_M  = 5'd7;
    localparam logic [POS_W-1:0] POS_SPACE   = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON   = 5'd13;
    localparam logic [POS_W-1:0] POS_YEAR_LO = 5'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
    localparam logic [FIELD_W-1:0] MONTH_FEB  = 7'd2;
    localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd23;
    localparam logic [FIELD_W-1:0] MINUTE_MAX = 7'd59;
    localparam logic [DAYS_W-1:0]  FEB_LEAP   = 5'd29;

    typedef struct packed {
        logic [FIELD_W-1:0] year_hi;
        logic [FIELD_W-1:0] year_lo;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic               form_ok;
    } tsv_fields_t;

    function automatic logic [DAYS_W-1:0] month_days(input logic [3:0] month);
        logic [DAYS_W-1:0] days;
        case (month)
            4'd2:                      days = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

    function automatic logic [FIELD_W-1:0] acc_digit(input logic [FIELD_W-1:0] v,
                                                     input logic [DIGIT_W-1:0] d);
        return (v << 3) + (v << 1) + FIELD_W'(d);
    endfunction

endpackage

@@ rtl/timestamp_string_validator.sv @@
// ----------------------------------------------------------------------------
// timestamp_string_validator
// Checks a "YYYY-MM-DD HH:MM" string sent one character per request.
// ----------------------------------------------------------------------------
// Characters enter an input register and are parsed one per cycle, so a new
// request is taken every clock while the result side keeps up. The request
// flagged as last yields one result after the input and result registers.
// The result holds 1 when the string has exactly sixteen characters in the
// right form and a real calendar date and clock time; parser state then
// clears for the next string. A pending result stalls only a following last
// character; other characters keep flowing.
module timestamp_string_validator
    import tsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res
);

    logic        hold_valid_reg;
    logic [7:0]  hold_ch_reg;
    logic        hold_last_reg;
    logic        res_valid_reg;
    logic        res_reg;
    logic        advance;
    logic        ok;
    tsv_fields_t fields;

    assign advance  = hold_valid_reg && (!hold_last_reg || !res_valid_reg || out_ready);
    assign in_ready = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (in_ready)
            hold_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_ch_reg   <= ch;
            hold_last_reg <= last;
        end
    end

    tsv_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .ch     (hold_ch_reg),
        .last   (hold_last_reg),
        .fields (fields)
    );

    tsv_checker u_checker (
        .fields (fields),
        .ok     (ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance && hold_last_reg)
            res_valid_reg <= 1'b1;
        else if (out_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && hold_last_reg)
            res_reg <= ok;
    end

    assign out_valid = res_valid_reg;
    assign valid_res = res_reg;

endmodule

@@ rtl/tsv_parser.sv @@
// ----------------------------------------------------------------------------
// tsv_parser
// Tracks the character position, checks separators and digits, and
// accumulates the date and time fields of the string in progress.
// ----------------------------------------------------------------------------
module tsv_parser
    import tsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  ch,
    input  logic        last,
    output tsv_fields_t fields
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [FIELD_W-1:0] year_hi_reg, year_hi_next;
    logic [FIELD_W-1:0] year_lo_reg, year_lo_next;
    logic [FIELD_W-1:0] month_reg, month_next;
    logic [FIELD_W-1:0] day_reg, day_next;
    logic [FIELD_W-1:0] hour_reg, hour_next;
    logic [FIELD_W-1:0] minute_reg, minute_next;
    logic               good_reg, good_next;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;

    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign digit    = DIGIT_W'(ch - CHAR_ZERO);

    always_comb
    begin
        year_hi_next = year_hi_reg;
        year_lo_next = year_lo_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        good_next    = good_reg;
        if (pos_reg >= POS_W'(TS_LENGTH))
        begin
            good_next = 1'b0;
        end
        else
        begin
            case (pos_reg)
                POS_DASH_Y, POS_DASH_M:
                begin
                    if (ch != CHAR_DASH)
                        good_next = 1'b0;
                end
                POS_SPACE:
                begin
                    if (ch != CHAR_SPACE)
                        good_next = 1'b0;
                end
                POS_COLON:
                begin
                    if (ch != CHAR_COLON)
                        good_next = 1'b0;
                end
                default:
                begin
                    if (!is_digit)
                        good_next = 1'b0;
                    else if (pos_reg < POS_YEAR_LO)
                        year_hi_next = acc_digit(year_hi_reg, digit);
                    else if (pos_reg < POS_DASH_Y)
                        year_lo_next = acc_digit(year_lo_reg, digit);
                    else if (pos_reg < POS_DASH_M)
                        month_next = acc_digit(month_reg, digit);
                    else if (pos_reg < POS_SPACE)
                        day_next = acc_digit(day_reg, digit);
                    else if (pos_reg < POS_COLON)
                        hour_next = acc_digit(hour_reg, digit);
                    else
                        minute_next = acc_digit(minute_reg, digit);
                end
            endcase
        end
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    end

    assign fields.year_hi = year_hi_next;
    assign fields.year_lo = year_lo_next;
    assign fields.month   = month_next;
    assign fields.day     = day_next;
    assign fields.hour    = hour_next;
    assign fields.minute  = minute_next;
    assign fields.form_ok = good_next && (pos_reg == POS_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            year_hi_reg <= '0;
            year_lo_reg <= '0;
            month_reg   <= '0;
            day_reg     <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            good_reg    <= 1'b1;
        end
        else if (fire)
        begin
            if (last)
            begin
                pos_reg     <= '0;
                year_hi_reg <= '0;
                year_lo_reg <= '0;
                month_reg   <= '0;
                day_reg     <= '0;
                hour_reg    <= '0;
                minute_reg  <= '0;
                good_reg    <= 1'b1;
            end
            else
            begin
                pos_reg     <= pos_next;
                year_hi_reg <= year_hi_next;
                year_lo_reg <= year_lo_next;
                month_reg   <= month_next;
                day_reg     <= day_next;
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
                good_reg    <= good_next;
            end
        end
    end

endmodule

@@ rtl/tsv_checker.sv @@
// ----------------------------------------------------------------------------
// tsv_checker
// Applies the calendar and clock range rules to a completed timestamp.
// ----------------------------------------------------------------------------
module tsv_checker
    import tsv_pkg::*;
(
    input  tsv_fields_t fields,
    output logic        ok
);

    logic              year_ok;
    logic              month_ok;
    logic              time_ok;
    logic              leap;
    logic              lo_zero;
    logic [DAYS_W-1:0] dim;
    logic              day_ok;

    // The year is held as two two-digit halves, so the tests by 4, 100 and
    // 400 reduce to the low bits and a zero test of the halves.
    assign lo_zero  = (fields.year_lo == '0);
    assign year_ok  = (fields.year_hi != '0) || !lo_zero;
    assign leap     = lo_zero ? (fields.year_hi[1:0] == 2'b00)
                              : (fields.year_lo[1:0] == 2'b00);
    assign month_ok = (fields.month inside {[7'd1:MONTH_MAX]});
    assign time_ok  = (fields.hour <= HOUR_MAX) && (fields.minute <= MINUTE_MAX);

    always_comb
    begin
        dim = month_days(fields.month[3:0]);
        if ((fields.month == MONTH_FEB) && leap)
            dim = FEB_LEAP;
    end

    assign day_ok = (fields.day != '0) && (fields.day <= FIELD_W'(dim));
    assign ok     = fields.form_ok && year_ok && month_ok && time_ok && day_ok;

endmodule

@@ sim/tb_timestamp_string_validator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_string_validator
// Sends "YYYY-MM-DD HH:MM" strings one character per request and checks every
// verdict against a behavioral parser kept in the testbench. Directed strings
// cover calendar limits, leap rules, bad digits, bad separators and wrong
// lengths. Random strings, mostly well formed, follow under three idling mixes.
// ----------------------------------------------------------------------------
module tb_timestamp_string_validator;
    import tsv_pkg::*;

    localparam int CLK_HIGH     = 5;
    localparam int CLK_LOW      = 5;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int YEAR_W       = 14;

    typedef logic [7:0] char_q_t[$];

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] ch        = 8'h00;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       valid_res;

    logic [POS_W-1:0]   next_pos;
    logic [YEAR_W-1:0]  acc_year;
    logic [FIELD_W-1:0] acc_month;
    logic [FIELD_W-1:0] acc_day;
    logic [FIELD_W-1:0] acc_hour;
    logic [FIELD_W-1:0] acc_minute;
    logic               form_ok;

    bit expected_verdicts[$];
    bit want_verdict;
    int mismatches    = 0;
    int sent_chars    = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    timestamp_string_validator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res)
    );

    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW  clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_timestamp_string_validator: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("verdict %0b arrived with nothing pending", valid_res);
            end
            else
            begin
                want_verdict = expected_verdicts.pop_front();
                if (valid_res !== want_verdict)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("verdict mismatch: expected %0b actual %0b",
                                 want_verdict, valid_res);
                end
            end
        end
    end

    function automatic bit calendar_ok();
        int month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        int len;
        if (acc_year == 0)
            return 1'b0;
        if (acc_month < 1 || acc_month > MONTH_MAX)
            return 1'b0;
        if (acc_hour > HOUR_MAX || acc_minute > MINUTE_MAX)
            return 1'b0;
        len = month_len[acc_month - 1];
        if (acc_month == MONTH_FEB &&
            ((acc_year % 4 == 0 && acc_year % 100 != 0) || acc_year % 400 == 0))
            len = FEB_LEAP;
        return (acc_day >= 1 && acc_day <= len);
    endfunction

    task automatic clear_parser();
        next_pos   = '0;
        acc_year   = '0;
        acc_month  = '0;
        acc_day    = '0;
        acc_hour   = '0;
        acc_minute = '0;
        form_ok    = 1'b1;
    endtask

    task automatic track_char(input logic [7:0] c, input logic is_last);
        logic [POS_W-1:0] p;
        logic             is_digit;
        int               d;
        p        = next_pos;
        is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
        d        = is_digit ? int'(c - CHAR_ZERO) : 0;
        if (p >= TS_LENGTH)
            form_ok = 1'b0;
        else if (p == POS_DASH_Y || p == POS_DASH_M)
        begin
            if (c != CHAR_DASH)
                form_ok = 1'b0;
        end
        else if (p == POS_SPACE)
        begin
            if (c != CHAR_SPACE)
                form_ok = 1'b0;
        end
        else if (p == POS_COLON)
        begin
            if (c != CHAR_COLON)
                form_ok = 1'b0;
        end
        else if (!is_digit)
            form_ok = 1'b0;
        else if (p < POS_DASH_Y)
            acc_year = YEAR_W'(acc_year * 10 + d);
        else if (p < POS_DASH_M)
            acc_month = FIELD_W'(acc_month * 10 + d);
        else if (p < POS_SPACE)
            acc_day = FIELD_W'(acc_day * 10 + d);
        else if (p < POS_COLON)
            acc_hour = FIELD_W'(acc_hour * 10 + d);
        else
            acc_minute = FIELD_W'(acc_minute * 10 + d);

        if (next_pos != POS_MAX)
            next_pos = next_pos + 1'b1;

        if (is_last)
        begin
            expected_verdicts.push_back(form_ok && p == POS_LAST && calendar_ok());
            clear_parser();
        end
    endtask

    function automatic char_q_t to_chars(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic char_q_t stamp_chars(input int y, input int mo, input int dd,
                                            input int h, input int mi);
        return to_chars($sformatf("%04d-%02d-%02d %02d:%02d", y, mo, dd, h, mi));
    endfunction

    task automatic send_string(input char_q_t chars);
        for (int i = 0; i < chars.size(); i++)
        begin
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            ch       <= chars[i];
            last     <= (i == chars.size() - 1);
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            track_char(chars[i], i == chars.size() - 1);
            sent_chars++;
        end
    endtask

    task automatic test_valid_dates();
        send_string(stamp_chars(1, 1, 1, 0, 0));
        send_string(stamp_chars(9999, 12, 31, 23, 59));
        send_string(stamp_chars(2020, 4, 30, 12, 34));
    endtask

    task automatic test_leap_rules();
        send_string(stamp_chars(2024, 2, 29, 23, 59));
        send_string(stamp_chars(2000, 2, 29, 12, 0));
        send_string(stamp_chars(1900, 2, 29, 12, 0));
        send_string(stamp_chars(2023, 2, 29, 12, 0));
        send_string(stamp_chars(2023, 2, 28, 12, 0));
    endtask

    task automatic test_field_limits();
        send_string(stamp_chars(0, 1, 1, 0, 0));
        send_string(stamp_chars(2020, 0, 10, 10, 10));
        send_string(stamp_chars(2020, 13, 10, 10, 10));
        send_string(stamp_chars(2020, 4, 31, 10, 10));
        send_string(stamp_chars(2020, 1, 0, 10, 10));
        send_string(stamp_chars(2020, 1, 1, 24, 0));
        send_string(stamp_chars(2020, 1, 1, 0, 60));
    endtask

    task automatic test_bad_digits();
        char_q_t q;
        q = stamp_chars(2020, 1, 1, 10, 10);
        q[1] = 8'h2F;
        send_string(q);
        q = stamp_chars(2020, 1, 1, 10, 10);
        q[6] = CHAR_COLON;
        send_string(q);
        q = stamp_chars(2020, 1, 1, 10, 10);
        q[0]  = 8'h00;
        q[15] = 8'hFF;
        send_string(q);
    endtask

    task automatic test_bad_separators();
        send_string(to_chars("2020/01-01 10:10"));
        send_string(to_chars("2020-01-01T10:10"));
        send_string(to_chars("2020-01-01 10-10"));
    endtask

    task automatic test_length_errors();
        char_q_t q;
        send_string(to_chars("2020-01-01 10:1"));
        send_string(to_chars("2020-01-01 10:100"));
        q = stamp_chars(2020, 1, 1, 10, 10);
        repeat (24)
            q.push_back(CHAR_ZERO);
        send_string(q);
        send_string(to_chars("5"));
        send_string(stamp_chars(2021, 6, 15, 8, 45));
    endtask

    task automatic test_random_stream(input int send_pct, input int recv_pct,
                                      input int n_chars);
        char_q_t q;
        int      start;
        int      kind;
        int      y;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = sent_chars;
        while (sent_chars - start < n_chars)
        begin
            case ($urandom_range(3))
                0:       y = $urandom_range(99) * 100;
                1:       y = $urandom_range(2499) * 4;
                default: y = $urandom_range(9999);
            endcase
            if ($urandom_range(3) == 0)
                q = stamp_chars(y, $urandom_range(99), $urandom_range(99),
                                $urandom_range(99), $urandom_range(99));
            else if ($urandom_range(3) == 0)
                q = stamp_chars(y, 2, $urandom_range(27, 30),
                                $urandom_range(23), $urandom_range(59));
            else
                q = stamp_chars(y, $urandom_range(12), $urandom_range(32),
                                $urandom_range(24), $urandom_range(60));
            kind = $urandom_range(99);
            if (kind >= 92)
            begin
                repeat ($urandom_range(1, 20))
                    q.push_back(8'($urandom_range(255)));
            end
            else if (kind >= 85)
                q = q[0:$urandom_range(14)];
            else if (kind >= 70)
                q[$urandom_range(15)] = 8'($urandom_range(255));
            send_string(q);
        end
    endtask

    initial
    begin
        clear_parser();
        send_idle_pct = 19;
        recv_idle_pct = 71;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_valid_dates();
        test_leap_rules();
        test_field_limits();
        test_bad_digits();
        test_bad_separators();
        test_length_errors();
        test_random_stream(19, 71, 240);
        test_random_stream(71, 19, 240);
        test_random_stream(0, 0, 240);

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("tb_timestamp_string_validator: PASS");
        else
            $display("tb_timestamp_string_validator: FAIL");
        $finish;
    end

endmodule
